// File: rtl/core/rmts_pkg.sv
// Shared types and constants for the rate monotonic tick scheduler.
package rmts_pkg;

  localparam int SLOTS          = 4;
  localparam int REG_W          = 10;
  localparam int NUM_TASKS_DEF  = 4;
  localparam int TIME_WIDTH_DEF = 10;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  localparam logic [2:0] REG_PERIOD_TASK0 = 3'd0;
  localparam logic [2:0] REG_PERIOD_TASK1 = 3'd1;
  localparam logic [2:0] REG_PERIOD_TASK2 = 3'd2;
  localparam logic [2:0] REG_PERIOD_TASK3 = 3'd3;
  localparam logic [2:0] REG_BUDGET_TASK0 = 3'd4;
  localparam logic [2:0] REG_BUDGET_TASK1 = 3'd5;
  localparam logic [2:0] REG_BUDGET_TASK2 = 3'd6;
  localparam logic [2:0] REG_BUDGET_TASK3 = 3'd7;

  typedef logic [REG_W-1:0] reg_val_t;

  typedef struct packed {
    reg_val_t [SLOTS-1:0] period;
    reg_val_t [SLOTS-1:0] budget;
  } rmts_cfg_t;

  typedef struct packed {
    logic [1:0]       running_task;
    logic             idle;
    logic [SLOTS-1:0] release_mask;
    logic [SLOTS-1:0] overrun_mask;
    logic             job_done;
  } rmts_result_t;

endpackage

// File: rtl/core/rmts_regs.sv
// Configuration register file with the APB-style access port.
module rmts_regs
  import rmts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output rmts_cfg_t         cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;
  reg_val_t   wr_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_val  = pwdata[REG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        cfg.period[i] <= reg_val_t'(1);
        cfg.budget[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERIOD_TASK0: cfg.period[0] <= wr_val;
        REG_PERIOD_TASK1: cfg.period[1] <= wr_val;
        REG_PERIOD_TASK2: cfg.period[2] <= wr_val;
        REG_PERIOD_TASK3: cfg.period[3] <= wr_val;
        REG_BUDGET_TASK0: cfg.budget[0] <= wr_val;
        REG_BUDGET_TASK1: cfg.budget[1] <= wr_val;
        REG_BUDGET_TASK2: cfg.budget[2] <= wr_val;
        REG_BUDGET_TASK3: cfg.budget[3] <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PERIOD_TASK0: prdata = DATA_W'(cfg.period[0]);
      REG_PERIOD_TASK1: prdata = DATA_W'(cfg.period[1]);
      REG_PERIOD_TASK2: prdata = DATA_W'(cfg.period[2]);
      REG_PERIOD_TASK3: prdata = DATA_W'(cfg.period[3]);
      REG_BUDGET_TASK0: prdata = DATA_W'(cfg.budget[0]);
      REG_BUDGET_TASK1: prdata = DATA_W'(cfg.budget[1]);
      REG_BUDGET_TASK2: prdata = DATA_W'(cfg.budget[2]);
      REG_BUDGET_TASK3: prdata = DATA_W'(cfg.budget[3]);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/rmts_core.sv
// Tick engine: request register, task counters, priority pick and result register.
module rmts_core
  import rmts_pkg::*;
#(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  rmts_cfg_t    cfg,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         restart,
  output logic         out_valid,
  input  logic         out_stall,
  output rmts_result_t result
);

  // Compare widths wide enough for both the register and the counter range.
  localparam int CW = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;
  localparam int PW = (TIME_WIDTH + 1 > REG_W) ? TIME_WIDTH + 1 : REG_W;
  localparam logic [CW-1:0] BUDGET_MAX = CW'({TIME_WIDTH{1'b1}});
  localparam logic [PW-1:0] PHASE_MAX  = PW'({TIME_WIDTH{1'b1}});

  logic                  in_full;
  logic                  in_restart;
  logic                  advance;
  logic [TIME_WIDTH-1:0] phase_count      [NUM_TASKS];
  logic [TIME_WIDTH-1:0] remaining_budget [NUM_TASKS];
  logic [TIME_WIDTH-1:0] phase_count_next      [NUM_TASKS];
  logic [TIME_WIDTH-1:0] remaining_budget_next [NUM_TASKS];
  logic [TIME_WIDTH-1:0] rem_rel [NUM_TASKS];
  logic [TIME_WIDTH-1:0] ph_cur  [NUM_TASKS];
  reg_val_t              eff_period [NUM_TASKS];
  logic [PW-1:0]         ph_inc  [NUM_TASKS];
  rmts_result_t          result_next;
  logic                  found;
  logic [1:0]            best;
  reg_val_t              best_period;

  // The request register moves on whenever the result register is free or drains.
  assign advance  = in_full & (~out_valid | ~out_stall);
  assign in_stall = in_full & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        phase_count[i]      <= '0;
        remaining_budget[i] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        for (int i = 0; i < NUM_TASKS; i++) begin
          phase_count[i]      <= phase_count_next[i];
          remaining_budget[i] <= remaining_budget_next[i];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_restart <= restart;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  always_comb begin
    result_next             = '0;
    found                   = 1'b0;
    best                    = '0;
    best_period             = '0;

    // Releases: a restart clears the counters and budgets before anything else.
    for (int i = 0; i < NUM_TASKS; i++) begin
      logic [TIME_WIDTH-1:0] rm_cur;
      ph_cur[i]     = in_restart ? '0 : phase_count[i];
      rm_cur        = in_restart ? '0 : remaining_budget[i];
      eff_period[i] = (cfg.period[i] == '0) ? reg_val_t'(1) : cfg.period[i];
      rem_rel[i]    = rm_cur;
      if (cfg.budget[i] == '0) begin
        rem_rel[i] = '0;
      end else if (ph_cur[i] == '0) begin
        result_next.release_mask[i] = 1'b1;
        result_next.overrun_mask[i] = (rm_cur != '0);
        rem_rel[i] = (CW'(cfg.budget[i]) > BUDGET_MAX) ? BUDGET_MAX[TIME_WIDTH-1:0]
                                                        : TIME_WIDTH'(cfg.budget[i]);
      end
    end

    // Shortest period wins; the strict compare keeps ties on the lower index.
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (cfg.budget[i] != '0 && rem_rel[i] != '0) begin
        if (!found || eff_period[i] < best_period) begin
          found       = 1'b1;
          best        = 2'(i);
          best_period = eff_period[i];
        end
      end
    end

    for (int i = 0; i < NUM_TASKS; i++) begin
      remaining_budget_next[i] = rem_rel[i];
      if (found && best == 2'(i)) begin
        remaining_budget_next[i] = rem_rel[i] - 1'b1;
        result_next.job_done     = (rem_rel[i] == TIME_WIDTH'(1));
      end
      ph_inc[i] = PW'(ph_cur[i]) + 1'b1;
      if (ph_inc[i] >= PW'(eff_period[i]) || ph_inc[i] > PHASE_MAX) begin
        phase_count_next[i] = '0;
      end else begin
        phase_count_next[i] = ph_inc[i][TIME_WIDTH-1:0];
      end
    end

    result_next.running_task = found ? best : 2'd0;
    result_next.idle         = ~found;
  end

endmodule

// File: rtl/core/rate_monotonic_tick_scheduler_unit.sv
// Top level of the rate monotonic tick scheduler for up to four periodic tasks.
//
// Each request on the input channel (in_valid, in_stall, restart) advances time by
// one tick. A task is released when its phase counter reaches zero, which reloads
// its budget; releasing a task whose previous job still owed ticks flags an overrun.
// The ready task with the shortest period runs for that tick, lower index first on
// ties. One result per request leaves on the output channel (out_valid, out_stall)
// with running_task, idle, release_mask, overrun_mask and job_done.
// A request waits in the request register, which feeds the counter update and
// priority pick; their outcome lands in the result register when the request advances.
// Throughput is one request per cycle while the receiver does not stall, as the
// counter update feeds the next tick's release and pick.
// When the receiver stalls, the result register holds its value and the request
// register can still fill, so in_stall rises only when both are occupied.
// Periods and budgets are written through the APB-style port at byte address 4*i,
// periods first, then budgets; pready is always high and reads return the value.
// A synchronous reset empties both registers, clears all phase counters and
// remaining budgets, and sets every period to 1 and every budget to 0.
module rate_monotonic_tick_scheduler_unit
  import rmts_pkg::*;
#(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        running_task,
  output logic              idle,
  output logic [SLOTS-1:0]  release_mask,
  output logic [SLOTS-1:0]  overrun_mask,
  output logic              job_done
);

  rmts_cfg_t    cfg;
  rmts_result_t result;

  rmts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmts_core #(
    .NUM_TASKS  (NUM_TASKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // The result register drives the payload ports directly.
  assign running_task = result.running_task;
  assign idle         = result.idle;
  assign release_mask = result.release_mask;
  assign overrun_mask = result.overrun_mask;
  assign job_done     = result.job_done;

endmodule
